// ===== rtl/lru_key_value_cache_defines.svh =====
// Assertion macros for the lru key/value cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define LKVC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lkvc assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define LKVC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lkvc assertion failed");

`endif

// ===== rtl/lkvc_pkg.sv =====
// Package: widths, codes and cell control type of the lru key/value cache.
`default_nettype none
package lkvc_pkg;

	localparam int DATA_W      = 32;
	localparam int KEY_FIELD_W = 16;
	localparam int CFG_W       = 5;
	localparam int IN_DATA_W   = KEY_FIELD_W + DATA_W;
	localparam int OUT_DATA_W  = DATA_W;

	localparam int ENTRIES_DEF  = 16;
	localparam int KEY_BITS_DEF = 16;

	localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

	typedef enum logic {
		MODE_GET = 1'b0,
		MODE_PUT = 1'b1
	} mode_t;

	// Broadcast from the top level to every cell.
	typedef struct packed {
		logic             update;
		logic             hit;
		logic             put;
		logic [CFG_W-1:0] limit;
	} cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/lkvc_cell.sv =====
// One cache cell: a key/value entry at a fixed recency position, shifting from its neighbor.
`default_nettype none
module lkvc_cell #(
	parameter int KW  = lkvc_pkg::KEY_BITS_DEF,
	parameter int IDX = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lkvc_pkg::cell_ctl_t         ctl,
	input  logic [KW-1:0]               look_key,
	input  logic                        prev_valid,
	input  logic [KW-1:0]               prev_key,
	input  logic [lkvc_pkg::DATA_W-1:0] prev_value,
	input  logic                        match_below,
	output logic                        match,
	output logic                        match_here_or_below,
	output logic                        ent_valid,
	output logic [KW-1:0]               ent_key,
	output logic [lkvc_pkg::DATA_W-1:0] ent_value
);
	import lkvc_pkg::*;

	logic              valid_q;
	logic [KW-1:0]     key_q;
	logic [DATA_W-1:0] value_q;
	logic              shift;
	logic              keep;

	assign match               = valid_q && (key_q == look_key);
	assign match_here_or_below = match || match_below;

	// hit: positions up to the hit one rotate; miss on put: whole row shifts
	assign shift = ctl.update && ((ctl.put && !ctl.hit) || (ctl.hit && match_here_or_below));
	// on an insert, positions at or past the limit fall off the end
	assign keep  = ctl.hit || (IDX == 0) || (int'(ctl.limit) > IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= prev_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			key_q   <= prev_key;
			value_q <= prev_value;
		end
	end

	assign ent_valid = valid_q;
	assign ent_key   = key_q;
	assign ent_value = value_q;

endmodule
`default_nettype wire

// ===== rtl/lru_key_value_cache.sv =====
// Top level: fully associative LRU key/value cache built as a row of recency-ordered cells.
// One input stage holds the accepted transaction; an output register then drives m_tvalid.
// Throughput: one transaction per cycle unless m_tready stalls the output; compare,
// rotate and insert across the row act together, so back-to-back items see updated state.
// Reset (arst_n low, asynchronous): all entries invalid, limit register 16,
// no pending input or output; stored keys and values are not cleared.
`default_nettype none
`include "lru_key_value_cache_defines.svh"
module lru_key_value_cache #(
	parameter int ENTRIES  = lkvc_pkg::ENTRIES_DEF,
	parameter int KEY_BITS = lkvc_pkg::KEY_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [lkvc_pkg::CFG_W-1:0]      cfg_wdata,  // active_entries
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [lkvc_pkg::IN_DATA_W-1:0]  s_tdata,    // [15:0] key, [47:16] value
	input  logic                            s_tuser,    // [0] mode
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [lkvc_pkg::OUT_DATA_W-1:0] m_tdata,    // [31:0] read_value
	output logic                            m_tuser     // [0] hit
);
	import lkvc_pkg::*;

	localparam int KW = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;

	logic [CFG_W-1:0]  active_q;
	logic              valid_s1;
	logic              put_s1;
	logic [KW-1:0]     key_s1;
	logic [DATA_W-1:0] value_s1;
	logic              out_valid_q;
	logic              out_hit_q;
	logic [DATA_W-1:0] out_data_q;
	logic              process;
	logic              hit;
	logic [DATA_W-1:0] hit_value;
	logic [DATA_W-1:0] head_value;
	cell_ctl_t         ctl;

	logic [ENTRIES-1:0] match_vec;
	logic [ENTRIES:0]   chain;
	logic               cell_valid [ENTRIES];
	logic [KW-1:0]      cell_key   [ENTRIES];
	logic [DATA_W-1:0]  cell_value [ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (cfg_wen) begin
			active_q <= cfg_wdata;
		end
	end

	assign process  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || process;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			put_s1   <= (mode_t'(s_tuser) == MODE_PUT);
			key_s1   <= s_tdata[KW-1:0];
			value_s1 <= s_tdata[KEY_FIELD_W +: DATA_W];
		end
	end

	assign hit = chain[0];

	always_comb begin
		hit_value = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match_vec[i]) begin
				hit_value = hit_value | cell_value[i];
			end
		end
	end

	// new head: the put value, or the hit entry's own value moving to the front
	assign head_value = put_s1 ? value_s1 : hit_value;

	always_comb begin
		ctl.update = process;
		ctl.hit    = hit;
		ctl.put    = put_s1;
		ctl.limit  = active_q;
	end

	assign chain[ENTRIES] = 1'b0;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		logic              prev_valid;
		logic [KW-1:0]     prev_key;
		logic [DATA_W-1:0] prev_value;

		if (g == 0) begin : g_head
			assign prev_valid = 1'b1;
			assign prev_key   = key_s1;
			assign prev_value = head_value;
		end else begin : g_body
			assign prev_valid = cell_valid[g-1];
			assign prev_key   = cell_key[g-1];
			assign prev_value = cell_value[g-1];
		end

		lkvc_cell #(
			.KW  (KW),
			.IDX (g)
		) u_cell (
			.clk                 (clk),
			.arst_n              (arst_n),
			.ctl                 (ctl),
			.look_key            (key_s1),
			.prev_valid          (prev_valid),
			.prev_key            (prev_key),
			.prev_value          (prev_value),
			.match_below         (chain[g+1]),
			.match               (match_vec[g]),
			.match_here_or_below (chain[g]),
			.ent_valid           (cell_valid[g]),
			.ent_key             (cell_key[g]),
			.ent_value           (cell_value[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (process) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			out_hit_q  <= hit;
			out_data_q <= (hit && !put_s1) ? hit_value : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_hit_q;
	assign m_tdata  = out_data_q;

	`LKVC_ASSERT_IMP(a_unique_match, 1'b1, $onehot0(match_vec))
	`LKVC_ASSERT_NXT(a_result_follows, process, out_valid_q)
	`LKVC_ASSERT_NXT(a_put_at_head, process && put_s1,
		cell_valid[0] && (cell_key[0] == $past(key_s1)))
	`LKVC_ASSERT_IMP(a_miss_reads_zero, out_valid_q && !out_hit_q, out_data_q == '0)

endmodule
`default_nettype wire
